/* rtl/pdm_pkg.sv */
// Shared types, codes and helpers of the PDO frame mapper.
// Used by every module of the block; depends on nothing else.
package pdm_pkg;

    localparam int DATA_W      = 64;
    localparam int LEN_W       = 7;
    localparam int LEN_SLOTS   = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int COB_W       = 11;
    localparam int FID_W       = 29;
    localparam int FLEN_W      = 4;
    localparam int LENS_W      = LEN_W * LEN_SLOTS;
    localparam int DEF_MAX_ENTRIES = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PDO_ENABLED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COB_ID        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LENGTHS = 4'd3;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_RX     = 2'd1;
    localparam logic [1:0] ERR_BUILD  = 2'd2;
    localparam logic [1:0] ERR_CONFIG = 2'd3;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_BUILD   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [FID_W-1:0]  frame_id;
        logic [FLEN_W-1:0] frame_length;
        logic [DATA_W-1:0] frame_data;
        logic [DATA_W-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        error_code;
        logic [IDX_W-1:0]  entry_index;
        logic [DATA_W-1:0] field_value;
        logic              last;
        logic [COB_W-1:0]  out_id;
        logic [FLEN_W-1:0] out_length;
        logic [DATA_W-1:0] out_data;
    } t_out_item;

    typedef struct packed {
        logic [COB_W-1:0]  cob_id;
        logic [CNT_W-1:0]  entry_count;
        logic [LENS_W-1:0] entry_lengths;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_ERR    = 2'd0,
        CMD_UNPACK = 2'd1,
        CMD_PACK   = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [1:0]        code;
        logic              clr;
        logic [LEN_W-1:0]  total;
        logic [DATA_W-1:0] word;
    } t_cmd;

    function automatic logic [LEN_W-1:0] len_of(input logic [LENS_W-1:0] lens,
                                                input logic [IDX_W-1:0] idx);
        len_of = lens[idx*LEN_W +: LEN_W];
    endfunction

    function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W-1:0] n);
        if (n >= LEN_W'(DATA_W)) begin
            low_mask = '1;
        end else begin
            low_mask = (DATA_W'(1) << n) - DATA_W'(1);
        end
    endfunction

endpackage

/* rtl/pdm_front.sv */
// Front end: configuration registers, configuration check and item classification.
// Depends on pdm_pkg; feeds commands to pdm_queue.
module pdm_front import pdm_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    input  logic                 i_q_full,
    output logic                 o_in_stall,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output t_cfg                 o_cfg,
    output logic                 o_cfg_clr
);

    localparam int LIMIT = (MAX_ENTRIES < LEN_SLOTS) ? MAX_ENTRIES : LEN_SLOTS;

    logic              r_enabled;
    logic [COB_W-1:0]  r_cob_id;
    logic [CNT_W-1:0]  r_entry_count;
    logic [LENS_W-1:0] r_entry_lengths;

    logic              cfg_ok;
    logic [9:0]        sum;
    logic [LEN_W-1:0]  n;
    logic              rx_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_cob_id        <= '0;
            r_entry_count   <= CNT_W'(1);
            r_entry_lengths <= LENS_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PDO_ENABLED:   r_enabled       <= i_cfg_data[0];
                CFG_COB_ID:        r_cob_id        <= i_cfg_data[COB_W-1:0];
                CFG_ENTRY_COUNT:   r_entry_count   <= i_cfg_data[CNT_W-1:0];
                CFG_ENTRY_LENGTHS: r_entry_lengths <= i_cfg_data[LENS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_clr = i_cfg_valid && (i_cfg_index inside {CFG_PDO_ENABLED, CFG_COB_ID,
                                                           CFG_ENTRY_COUNT, CFG_ENTRY_LENGTHS});

    always_comb begin
        cfg_ok = (r_entry_count != '0) && (r_entry_count <= CNT_W'(LIMIT));
        sum    = '0;
        n      = '0;
        for (int i = 0; i < LEN_SLOTS; i++) begin
            if (CNT_W'(i) < r_entry_count) begin
                n = len_of(r_entry_lengths, IDX_W'(i));
                if (n == '0 || n > LEN_W'(DATA_W)) begin
                    cfg_ok = 1'b0;
                end
                sum = sum + 10'(n);
            end
        end
        if (sum > 10'(DATA_W)) begin
            cfg_ok = 1'b0;
        end
    end

    assign rx_bad = (i_in_item.frame_id != FID_W'(r_cob_id)) ||
                    ({i_in_item.frame_length, 3'b000} < {3'b000, sum[LEN_W-1:0]});

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = CMD_ERR;
        o_cmd.total = sum[LEN_W-1:0];
        if (!r_enabled) begin
            o_cmd.code = (i_in_item.op == OP_RECEIVE) ? ERR_RX : ERR_BUILD;
            o_cmd.clr  = 1'b1;
        end else if (!cfg_ok) begin
            o_cmd.code = ERR_CONFIG;
            o_cmd.clr  = 1'b1;
        end else if (i_in_item.op == OP_BUILD) begin
            o_cmd.op   = CMD_PACK;
            o_cmd.word = i_in_item.entry_value;
        end else if (rx_bad) begin
            o_cmd.code = ERR_RX;
        end else begin
            o_cmd.op   = CMD_UNPACK;
            o_cmd.word = i_in_item.frame_data;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign o_cfg.cob_id        = r_cob_id;
    assign o_cfg.entry_count   = r_entry_count;
    assign o_cfg.entry_lengths = r_entry_lengths;

endmodule

/* rtl/pdm_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on pdm_pkg for the command type.
module pdm_queue import pdm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output logic o_empty,
    output logic o_full,
    output t_cmd o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rd + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

/* rtl/pdm_back.sv */
// Back end: executes queued commands, holds the pack state and the output register.
// Depends on pdm_pkg; takes configuration from pdm_front.
module pdm_back import pdm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cfg_clr,
    input  logic      i_q_empty,
    input  t_cmd      i_q_head,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic {
        S_IDLE,
        S_UNPACK
    } t_state;

    t_state            r_state,    n_state;
    logic [DATA_W-1:0] r_data,     n_data;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [LEN_W-1:0]  r_off,      n_off;
    logic [CNT_W-1:0]  r_pack_idx, n_pack_idx;
    logic [LEN_W-1:0]  r_pack_off, n_pack_off;
    logic [DATA_W-1:0] r_pack_buf, n_pack_buf;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,      n_out;

    logic              out_free;
    logic              pack_wrap;
    logic [CNT_W-1:0]  base_idx;
    logic [LEN_W-1:0]  base_off;
    logic [DATA_W-1:0] base_buf;
    logic [LEN_W-1:0]  pack_n;
    logic [DATA_W-1:0] pack_new;
    logic [CNT_W-1:0]  pack_next;
    logic              pack_done;
    logic [LEN_W-1:0]  unp_n;
    logic [DATA_W-1:0] unp_val;
    logic [7:0]        len_round;

    assign out_free  = !r_out_valid || !i_out_stall;

    assign pack_wrap = (r_pack_idx >= i_cfg.entry_count);
    assign base_idx  = pack_wrap ? '0 : r_pack_idx;
    assign base_off  = pack_wrap ? '0 : r_pack_off;
    assign base_buf  = pack_wrap ? '0 : r_pack_buf;
    assign pack_n    = len_of(i_cfg.entry_lengths, base_idx[IDX_W-1:0]);
    assign pack_new  = base_buf | ((i_q_head.word & low_mask(pack_n)) << base_off);
    assign pack_next = base_idx + CNT_W'(1);
    assign pack_done = (pack_next >= i_cfg.entry_count);
    assign len_round = ({1'b0, i_q_head.total} + 8'd7) >> 3;

    assign unp_n     = len_of(i_cfg.entry_lengths, r_idx);
    assign unp_val   = (r_data >> r_off) & low_mask(unp_n);

    always_comb begin
        n_state     = r_state;
        n_data      = r_data;
        n_idx       = r_idx;
        n_off       = r_off;
        n_pack_idx  = r_pack_idx;
        n_pack_off  = r_pack_off;
        n_pack_buf  = r_pack_buf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        if (i_cfg_clr) begin
            n_pack_idx = '0;
            n_pack_off = '0;
            n_pack_buf = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_head.op)
                        CMD_ERR: begin
                            n_out            = '0;
                            n_out.kind       = KIND_ERROR;
                            n_out.error_code = i_q_head.code;
                            n_out.last       = 1'b1;
                            n_out_valid      = 1'b1;
                            if (i_q_head.clr) begin
                                n_pack_idx = '0;
                                n_pack_off = '0;
                                n_pack_buf = '0;
                            end
                        end
                        CMD_UNPACK: begin
                            n_data  = i_q_head.word;
                            n_idx   = '0;
                            n_off   = '0;
                            n_state = S_UNPACK;
                        end
                        CMD_PACK: begin
                            if (pack_done) begin
                                n_out            = '0;
                                n_out.kind       = KIND_FRAME;
                                n_out.error_code = ERR_NONE;
                                n_out.last       = 1'b1;
                                n_out.out_id     = i_cfg.cob_id;
                                n_out.out_length = len_round[FLEN_W-1:0];
                                n_out.out_data   = pack_new;
                                n_out_valid      = 1'b1;
                                n_pack_idx       = '0;
                                n_pack_off       = '0;
                                n_pack_buf       = '0;
                            end else begin
                                n_pack_idx = pack_next;
                                n_pack_off = base_off + pack_n;
                                n_pack_buf = pack_new;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UNPACK: begin
                if (out_free) begin
                    n_out             = '0;
                    n_out.kind        = KIND_VALUE;
                    n_out.error_code  = ERR_NONE;
                    n_out.entry_index = r_idx;
                    n_out.field_value = unp_val;
                    n_out.last        = ({1'b0, r_idx} + CNT_W'(1)) >= i_cfg.entry_count;
                    n_out_valid       = 1'b1;
                    n_idx             = r_idx + IDX_W'(1);
                    n_off             = r_off + unp_n;
                    if (n_out.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pack_idx  <= '0;
            r_pack_off  <= '0;
            r_pack_buf  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pack_idx  <= n_pack_idx;
            r_pack_off  <= n_pack_off;
            r_pack_buf  <= n_pack_buf;
            r_out_valid <= n_out_valid;
        end
        r_data <= n_data;
        r_idx  <= n_idx;
        r_off  <= n_off;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/pdo_frame_mapper_unit.sv */
// Usage notes:
// Maps CAN payloads to and from up to eight configured bit fields.
// Input channel (i_in_valid / o_in_stall / i_in_item): op 0 carries a received
// frame to unpack, op 1 carries the value of the next field to pack.
// Output channel (o_out_valid / i_out_stall / o_out_item): unpacked values,
// built frames and errors; last marks the final result of an item.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): write
// only while idle; o_cfg_ready is always high. Writes to indices 0-3 clear the
// pack state. Errors and built frames pass the queue and the output register;
// an unpacked frame passes the queue and the frame register, then gives one
// value per cycle while the receiver does not stall. The back end pops error
// and build items whenever its output is free, and none while a frame has
// fields left. A two-entry queue sits between classification and execution.
// Reset clears configuration to disabled, one 8-bit entry, and empties the
// queue and the pack state. When the receiver stalls, the output item holds,
// the back end waits and the queue fills; o_in_stall rises once it is full.
// Depends on pdm_pkg, pdm_front, pdm_queue and pdm_back.
module pdo_frame_mapper_unit import pdm_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    logic cfg_write;
    logic cfg_clr;
    t_cfg cfg;
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    pdm_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg),
        .o_cfg_clr   (cfg_clr)
    );

    pdm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_full     (q_full),
        .o_head     (q_head)
    );

    pdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cfg_clr   (cfg_clr),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_ERROR |->
            o_out_item.last && o_out_item.error_code != ERR_NONE)
        else $error("error result without last or code");

    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_FRAME |->
            o_out_item.last && o_out_item.out_length <= FLEN_W'(8) &&
            o_out_item.out_id == cfg.cob_id)
        else $error("malformed built frame");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    a_value_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_VALUE |->
            {1'b0, o_out_item.entry_index} < cfg.entry_count)
        else $error("unpacked entry index beyond entry count");

endmodule
